/* rtl/core/plane_plane_intersection_core_assert.svh */
// ---------------------------------------------------------------------------
// plane_plane_intersection_core assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef PLANE_PLANE_INTERSECTION_CORE_ASSERT_SVH
`define PLANE_PLANE_INTERSECTION_CORE_ASSERT_SVH

// same-cycle implication
`define PPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ppi_pkg.sv */
// ---------------------------------------------------------------------------
// ppi_pkg
// word types and fixed point helpers for the plane intersection core
// ---------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_p;
    typedef logic signed [32:0] t_add;

    typedef struct packed {
        t_q plane_a_normal_x;
        t_q plane_a_normal_y;
        t_q plane_a_normal_z;
        t_q plane_a_offset;
        t_q plane_b_normal_x;
        t_q plane_b_normal_y;
        t_q plane_b_normal_z;
        t_q plane_b_offset;
    } t_in_word;

    typedef struct packed {
        logic valid_res;
        t_q   line_point_x;
        t_q   line_point_y;
        t_q   line_point_z;
        t_q   line_dir_x;
        t_q   line_dir_y;
        t_q   line_dir_z;
    } t_out_word;

    function automatic t_p mul(input t_q a, input t_q b);
        return 64'(a) * 64'(b);
    endfunction

    function automatic t_q sat32(input logic signed [67:0] v);
        t_q res;
        if (v > 68'sh7fffffff) begin
            res = 32'sh7fffffff;
        end else if (v < -68'sh80000000) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // sum of three q32.32 terms plus a q16.16 addend, rounded half up, saturated
    function automatic t_q lin3(input t_p p0, input t_p p1, input t_p p2, input t_add add);
        logic signed [67:0] s;
        s = 68'(p0) + 68'(p1) + 68'(p2) + (68'(add) <<< 16) + 68'sh8000;
        return sat32(s >>> 16);
    endfunction

    function automatic t_add ext_neg(input t_q x);
        return -(33'(x));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ppi_if.sv */
// ---------------------------------------------------------------------------
// ppi_if
// valid/ready channel carrying one word of type T
// ---------------------------------------------------------------------------
`default_nettype none

interface ppi_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ppi_sqrt.sv */
// ---------------------------------------------------------------------------
// ppi_sqrt
// pipelined floor square root of a 64-bit value, one result bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module ppi_sqrt #(
    parameter int W = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_val,
    input  logic [W-1:0]  i_side,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [W-1:0]  o_side
);

    localparam int N = 32;

    logic          r_vld  [N];
    logic [63:0]   r_v    [N];
    logic [63:0]   r_r    [N];
    logic [W-1:0]  r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic          w_vld;
        logic [63:0]   w_v;
        logic [63:0]   w_r;
        logic [W-1:0]  w_side;
        logic [63:0]   n_v;
        logic [63:0]   n_r;

        if (k == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_v    = i_val;
            assign w_r    = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_v    = r_v[k-1];
            assign w_r    = r_r[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            logic [63:0] b;
            logic [63:0] t;
            b = 64'd1 << (62 - 2 * k);
            t = w_r + b;
            if (w_v >= t) begin
                n_v = w_v - t;
                n_r = (w_r >> 1) + b;
            end else begin
                n_v = w_v;
                n_r = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k]    <= n_v;
                r_r[k]    <= n_r;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_r[N-1][31:0];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

/* rtl/core/ppi_div.sv */
// ---------------------------------------------------------------------------
// ppi_div
// pipelined signed (num * 2^16) / den over L lanes, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module ppi_div #(
    parameter int L = 1,
    parameter int W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [L-1:0][31:0]    i_num,
    input  logic [31:0]           i_den,
    input  logic [W-1:0]          i_side,
    output logic                  o_valid,
    output logic [L-1:0][31:0]    o_quo,
    output logic [W-1:0]          o_side
);

    localparam int N = 48;

    logic                 r_vld  [N];
    logic [L-1:0][31:0]   r_rem  [N];
    logic [L-1:0][47:0]   r_q    [N];
    logic [L-1:0]         r_neg  [N];
    logic [31:0]          r_den  [N];
    logic [W-1:0]         r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic                 w_vld;
        logic [L-1:0][31:0]   w_rem;
        logic [L-1:0][47:0]   w_q;
        logic [L-1:0]         w_neg;
        logic [31:0]          w_den;
        logic [W-1:0]         w_side;
        logic [L-1:0][31:0]   n_rem;
        logic [L-1:0][47:0]   n_q;

        if (k == 0) begin : g_first
            always_comb begin
                logic [31:0] mag;
                for (int l = 0; l < L; l++) begin
                    mag      = i_num[l][31] ? (32'd0 - i_num[l]) : i_num[l];
                    w_rem[l] = '0;
                    w_q[l]   = {mag, 16'h0000};
                    w_neg[l] = i_num[l][31];
                end
            end
            assign w_vld  = i_valid;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_q    = r_q[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            logic [32:0] t;
            for (int l = 0; l < L; l++) begin
                t = {w_rem[l], w_q[l][47]};
                if (t >= {1'b0, w_den}) begin
                    n_rem[l] = 32'(t - {1'b0, w_den});
                    n_q[l]   = {w_q[l][46:0], 1'b1};
                end else begin
                    n_rem[l] = t[31:0];
                    n_q[l]   = {w_q[l][46:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_neg[k]  <= w_neg;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    // sign, saturation, zero divisor
    always_comb begin
        logic [47:0] q;
        logic [47:0] t;
        for (int l = 0; l < L; l++) begin
            q = r_q[N-1][l];
            t = 48'd0 - q;
            if (r_den[N-1] == '0) begin
                o_quo[l] = '0;
            end else if (!r_neg[N-1][l]) begin
                o_quo[l] = (q > 48'h7fffffff) ? 32'h7fffffff : q[31:0];
            end else begin
                o_quo[l] = (q > 48'h80000000) ? 32'h80000000 : t[31:0];
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_side  = r_side[N-1];

endmodule

`default_nettype wire

/* rtl/core/plane_plane_intersection_core.sv */
// ---------------------------------------------------------------------------
// plane_plane_intersection_core
// line of intersection of two q16.16 planes, fully pipelined
// ---------------------------------------------------------------------------
// i_in carries one word per plane pair (two normals and two offsets);
// o_out carries the line: valid_res, a foot point and the unit direction.
// a word is moved when valid and ready are both high.
// throughput: one word per cycle while the pipeline is not stalled. the pipeline is
// built from two 32-stage square roots, two 48-stage dividers and
// 14 arithmetic stages around them.
// the whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken. while the receiver holds ready low
// with a word waiting, every stage holds and i_in.ready is low; nothing is
// lost or repeated.
// reset clears all valid bits; the pipeline is empty afterwards.
// parallel planes give valid_res = 0 and all other fields zero.
// ---------------------------------------------------------------------------
`default_nettype none

module plane_plane_intersection_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppi_if.sink         i_in,
    ppi_if.source       o_out
);

    import ppi_pkg::*;

    typedef struct packed {
        t_q [2:0] na;
        t_q       oa;
        t_q [2:0] nb;
        t_q       ob;
        t_q [2:0] c;
        t_q [2:0] pa;
        t_q       pdist;
        t_q [2:0] dir;
        t_q       r;
        t_q [2:0] e0;
        logic     nz;
    } t_ctx;

    localparam int CW = $bits(t_ctx);

    logic       w_en;
    logic       r_out_vld;
    t_out_word  r_out;

    assign w_en       = o_out.ready || !r_out_vld;
    assign i_in.ready = w_en;

    // stage 1: cross and start point products
    t_ctx      w_c0;
    logic      r_v1;
    t_ctx      r_c1;
    t_p [5:0]  r_cp1;
    t_p [2:0]  r_pp1;

    always_comb begin
        w_c0       = '0;
        w_c0.na[0] = i_in.data.plane_a_normal_x;
        w_c0.na[1] = i_in.data.plane_a_normal_y;
        w_c0.na[2] = i_in.data.plane_a_normal_z;
        w_c0.oa    = i_in.data.plane_a_offset;
        w_c0.nb[0] = i_in.data.plane_b_normal_x;
        w_c0.nb[1] = i_in.data.plane_b_normal_y;
        w_c0.nb[2] = i_in.data.plane_b_normal_z;
        w_c0.ob    = i_in.data.plane_b_offset;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1     <= w_c0;
            r_cp1[0] <= mul(w_c0.na[1], w_c0.nb[2]);
            r_cp1[1] <= mul(w_c0.na[2], w_c0.nb[1]);
            r_cp1[2] <= mul(w_c0.na[2], w_c0.nb[0]);
            r_cp1[3] <= mul(w_c0.na[0], w_c0.nb[2]);
            r_cp1[4] <= mul(w_c0.na[0], w_c0.nb[1]);
            r_cp1[5] <= mul(w_c0.na[1], w_c0.nb[0]);
            for (int i = 0; i < 3; i++) begin
                r_pp1[i] <= mul(w_c0.na[i], w_c0.oa);
            end
        end
    end

    // stage 2: round cross and start point
    logic r_v2;
    t_ctx r_c2;
    t_ctx n_c2;

    always_comb begin
        n_c2      = r_c1;
        n_c2.c[0] = lin3(r_cp1[0], -r_cp1[1], '0, '0);
        n_c2.c[1] = lin3(r_cp1[2], -r_cp1[3], '0, '0);
        n_c2.c[2] = lin3(r_cp1[4], -r_cp1[5], '0, '0);
        for (int i = 0; i < 3; i++) begin
            n_c2.pa[i] = lin3(r_pp1[i], '0, '0, '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c2 <= n_c2;
        end
    end

    // stage 3: squares of cross, start point against plane b
    logic             r_v3;
    t_ctx             r_c3;
    logic [2:0][63:0] r_sq3;
    t_p [2:0]         r_dp3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3 <= r_c2;
            for (int i = 0; i < 3; i++) begin
                r_sq3[i] <= mul(r_c2.c[i], r_c2.c[i]);
                r_dp3[i] <= mul(r_c2.nb[i], r_c2.pa[i]);
            end
        end
    end

    // stage 4: squared magnitude, distance to plane b
    logic        r_v4;
    t_ctx        r_c4;
    t_ctx        n_c4;
    logic [63:0] r_msq4;

    always_comb begin
        n_c4       = r_c3;
        n_c4.pdist = lin3(r_dp3[0], r_dp3[1], r_dp3[2], ext_neg(r_c3.ob));
        n_c4.nz    = (r_c3.c != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c4   <= n_c4;
            r_msq4 <= r_sq3[0] + r_sq3[1] + r_sq3[2];
        end
    end

    // magnitude of cross, then direction and step length
    logic            w_va;
    logic [31:0]     w_ma;
    logic [CW-1:0]   w_sa;
    t_ctx            w_ca;

    ppi_sqrt #(.W(CW)) u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_val   (r_msq4),
        .i_side  (r_c4),
        .o_valid (w_va),
        .o_root  (w_ma),
        .o_side  (w_sa)
    );

    assign w_ca = w_sa;

    logic               w_vb;
    logic [3:0][31:0]   w_qb;
    logic [CW-1:0]      w_sb;
    t_ctx               w_cb;

    ppi_div #(.L(4), .W(CW)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_va),
        .i_num   ({w_ca.pdist, w_ca.c[2], w_ca.c[1], w_ca.c[0]}),
        .i_den   (w_ma),
        .i_side  (w_ca),
        .o_valid (w_vb),
        .o_quo   (w_qb),
        .o_side  (w_sb)
    );

    assign w_cb = w_sb;

    // stage 5: in-plane edge vector products
    logic     r_v5;
    t_ctx     r_c5;
    t_ctx     n_c5;
    t_p [5:0] r_ep5;

    always_comb begin
        n_c5        = w_cb;
        n_c5.dir[0] = w_qb[0];
        n_c5.dir[1] = w_qb[1];
        n_c5.dir[2] = w_qb[2];
        n_c5.r      = w_qb[3];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c5     <= n_c5;
            r_ep5[0] <= mul(w_cb.na[1], w_qb[2]);
            r_ep5[1] <= mul(w_cb.na[2], w_qb[1]);
            r_ep5[2] <= mul(w_cb.na[2], w_qb[0]);
            r_ep5[3] <= mul(w_cb.na[0], w_qb[2]);
            r_ep5[4] <= mul(w_cb.na[0], w_qb[1]);
            r_ep5[5] <= mul(w_cb.na[1], w_qb[0]);
        end
    end

    // stage 6: round edge vector
    logic r_v6;
    t_ctx r_c6;
    t_ctx n_c6;

    always_comb begin
        n_c6       = r_c5;
        n_c6.e0[0] = lin3(r_ep5[0], -r_ep5[1], '0, '0);
        n_c6.e0[1] = lin3(r_ep5[2], -r_ep5[3], '0, '0);
        n_c6.e0[2] = lin3(r_ep5[4], -r_ep5[5], '0, '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c6 <= n_c6;
        end
    end

    // stage 7: squares of edge vector
    logic             r_v7;
    t_ctx             r_c7;
    logic [2:0][63:0] r_sq7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c7 <= r_c6;
            for (int i = 0; i < 3; i++) begin
                r_sq7[i] <= mul(r_c6.e0[i], r_c6.e0[i]);
            end
        end
    end

    // stage 8: squared magnitude of edge vector
    logic        r_v8;
    t_ctx        r_c8;
    logic [63:0] r_msq8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c8   <= r_c7;
            r_msq8 <= r_sq7[0] + r_sq7[1] + r_sq7[2];
        end
    end

    logic            w_vc;
    logic [31:0]     w_mc;
    logic [CW-1:0]   w_sc;
    t_ctx            w_cc;

    ppi_sqrt #(.W(CW)) u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v8),
        .i_val   (r_msq8),
        .i_side  (r_c8),
        .o_valid (w_vc),
        .o_root  (w_mc),
        .o_side  (w_sc)
    );

    assign w_cc = w_sc;

    logic               w_vd;
    logic [2:0][31:0]   w_qd;
    logic [CW-1:0]      w_sd;
    t_ctx               w_cd;

    ppi_div #(.L(3), .W(CW)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vc),
        .i_num   ({w_cc.e0[2], w_cc.e0[1], w_cc.e0[0]}),
        .i_den   (w_mc),
        .i_side  (w_cc),
        .o_valid (w_vd),
        .o_quo   (w_qd),
        .o_side  (w_sd)
    );

    assign w_cd = w_sd;

    // stage 9: step products
    logic     r_v9;
    t_ctx     r_c9;
    t_p [2:0] r_st9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c9 <= w_cd;
            for (int i = 0; i < 3; i++) begin
                r_st9[i] <= mul(w_qd[i], w_cd.r);
            end
        end
    end

    // stage 10: forward and backward candidates
    logic     r_v10;
    t_ctx     r_c10;
    t_q [2:0] r_pos10;
    t_q [2:0] r_neg10;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c10 <= r_c9;
            for (int i = 0; i < 3; i++) begin
                r_pos10[i] <= lin3(r_st9[i], '0, '0, 33'(r_c9.pa[i]));
                r_neg10[i] <= lin3(-r_st9[i], '0, '0, 33'(r_c9.pa[i]));
            end
        end
    end

    // stage 11: candidate against both planes
    logic     r_v11;
    t_ctx     r_c11;
    t_q [2:0] r_pos11;
    t_q [2:0] r_neg11;
    t_p [2:0] r_ap11;
    t_p [2:0] r_bp11;
    t_p [2:0] r_an11;
    t_p [2:0] r_bn11;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c11   <= r_c10;
            r_pos11 <= r_pos10;
            r_neg11 <= r_neg10;
            for (int i = 0; i < 3; i++) begin
                r_ap11[i] <= mul(r_c10.na[i], r_pos10[i]);
                r_bp11[i] <= mul(r_c10.nb[i], r_pos10[i]);
                r_an11[i] <= mul(r_c10.na[i], r_neg10[i]);
                r_bn11[i] <= mul(r_c10.nb[i], r_neg10[i]);
            end
        end
    end

    // stage 12: plane distances
    logic     r_v12;
    t_ctx     r_c12;
    t_q [2:0] r_pos12;
    t_q [2:0] r_neg12;
    t_q [3:0] r_d12;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c12    <= r_c11;
            r_pos12  <= r_pos11;
            r_neg12  <= r_neg11;
            r_d12[0] <= lin3(r_ap11[0], r_ap11[1], r_ap11[2], ext_neg(r_c11.oa));
            r_d12[1] <= lin3(r_bp11[0], r_bp11[1], r_bp11[2], ext_neg(r_c11.ob));
            r_d12[2] <= lin3(r_an11[0], r_an11[1], r_an11[2], ext_neg(r_c11.oa));
            r_d12[3] <= lin3(r_bn11[0], r_bn11[1], r_bn11[2], ext_neg(r_c11.ob));
        end
    end

    // stage 13: squared distances
    logic             r_v13;
    t_ctx             r_c13;
    t_q [2:0]         r_pos13;
    t_q [2:0]         r_neg13;
    logic [3:0][63:0] r_sq13;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c13   <= r_c12;
            r_pos13 <= r_pos12;
            r_neg13 <= r_neg12;
            for (int i = 0; i < 4; i++) begin
                r_sq13[i] <= mul(r_d12[i], r_d12[i]);
            end
        end
    end

    // stage 14: pick candidate, backward wins a tie
    t_out_word w_out;

    always_comb begin
        logic [63:0] sp;
        logic [63:0] sn;
        logic        fwd;
        sp    = r_sq13[0] + r_sq13[1];
        sn    = r_sq13[2] + r_sq13[3];
        fwd   = (sp < sn);
        w_out = '0;
        if (r_c13.nz) begin
            w_out.valid_res    = 1'b1;
            w_out.line_point_x = fwd ? r_pos13[0] : r_neg13[0];
            w_out.line_point_y = fwd ? r_pos13[1] : r_neg13[1];
            w_out.line_point_z = fwd ? r_pos13[2] : r_neg13[2];
            w_out.line_dir_x   = r_c13.dir[0];
            w_out.line_dir_y   = r_c13.dir[1];
            w_out.line_dir_z   = r_c13.dir[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_v6      <= 1'b0;
            r_v7      <= 1'b0;
            r_v8      <= 1'b0;
            r_v9      <= 1'b0;
            r_v10     <= 1'b0;
            r_v11     <= 1'b0;
            r_v12     <= 1'b0;
            r_v13     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v1      <= i_in.valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= w_vb;
            r_v6      <= r_v5;
            r_v7      <= r_v6;
            r_v8      <= r_v7;
            r_v9      <= w_vd;
            r_v10     <= r_v9;
            r_v11     <= r_v10;
            r_v12     <= r_v11;
            r_v13     <= r_v12;
            r_out_vld <= r_v13;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

`include "plane_plane_intersection_core_assert.svh"

    `PPI_ASSERT_NOW(a_ready_rule, 1'b1, i_in.ready == (o_out.ready || !o_out.valid), "ready rule")
    `PPI_ASSERT_NOW(a_parallel_zero, o_out.valid && !o_out.data.valid_res, o_out.data[191:0] == '0, "parallel word not zero")
    `PPI_ASSERT_NEXT(a_stall_hold, !w_en, $stable(r_v1) && $stable(r_c1) && $stable(r_v13), "stall moved pipe")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// line of intersection of two planes: random and corner plane pairs are
// pushed through the core, each output word is checked field by field
// against an in-bench fixed point predictor, with random stalls on both ends
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import ppi_pkg::*;

    localparam int LATENCY   = 174;
    localparam int MAX_CYCLE = 1000000;

    typedef logic signed [127:0] t_wide;

    logic i_clk;
    logic i_rst_n;

    ppi_if #(.T(t_in_word))  in_ch ();
    ppi_if #(.T(t_out_word)) out_ch ();

    plane_plane_intersection_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_in_word  pending_pairs[$];
    t_out_word expected_lines[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        n_fail;
    int        cycle_count;
    bit        stim_done;
    bit        in_taken;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // round half up of a q32.32 sum plus a q16.16 addend, saturated
    function automatic t_q rnd_sat(input t_wide s, input t_wide add);
        t_wide v;
        v = (s + (add <<< 16) + 128'sh8000) >>> 16;
        if (v > 128'sh7fffffff) return 32'sh7fffffff;
        if (v < -128'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_q div_sat(input t_wide num, input t_wide den);
        t_wide v;
        v = num / den;
        if (v > 128'sh7fffffff) return 32'sh7fffffff;
        if (v < -128'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_wide prod(input t_q a, input t_q b);
        return t_wide'(a) * t_wide'(b);
    endfunction

    function automatic t_wide root_floor(input t_wide v);
        t_wide r;
        t_wide b;
        r = 0;
        b = t_wide'(1) <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic void cross_q(input t_q u[3], input t_q v[3], output t_q o[3]);
        o[0] = rnd_sat(prod(u[1], v[2]) - prod(u[2], v[1]), 0);
        o[1] = rnd_sat(prod(u[2], v[0]) - prod(u[0], v[2]), 0);
        o[2] = rnd_sat(prod(u[0], v[1]) - prod(u[1], v[0]), 0);
    endfunction

    function automatic t_wide mag_sq(input t_q v[3]);
        return prod(v[0], v[0]) + prod(v[1], v[1]) + prod(v[2], v[2]);
    endfunction

    function automatic t_wide unit_vec(input t_q v[3], output t_q o[3]);
        t_wide m;
        m = root_floor(mag_sq(v));
        for (int i = 0; i < 3; i++) o[i] = (m == 0) ? 32'sd0 : div_sat(t_wide'(v[i]) <<< 16, m);
        return m;
    endfunction

    function automatic t_q dist_to(input t_q n[3], input t_q off, input t_q p[3]);
        return rnd_sat(prod(n[0], p[0]) + prod(n[1], p[1]) + prod(n[2], p[2]),
                       -t_wide'(off));
    endfunction

    function automatic t_wide err_sum(input t_q na[3], input t_q oa, input t_q nb[3],
                                      input t_q ob, input t_q p[3]);
        t_wide da;
        t_wide db;
        da = dist_to(na, oa, p);
        db = dist_to(nb, ob, p);
        return ((da * da) & 128'hffffffffffffffff) + ((db * db) & 128'hffffffffffffffff);
    endfunction

    function automatic t_out_word intersect_line(input t_in_word w);
        t_q na[3], nb[3], c[3], dir[3], e0[3], e[3], pa[3], pos[3], neg[3], pt[3];
        t_q pdist, r;
        t_wide m, step;
        t_out_word res;
        na = '{w.plane_a_normal_x, w.plane_a_normal_y, w.plane_a_normal_z};
        nb = '{w.plane_b_normal_x, w.plane_b_normal_y, w.plane_b_normal_z};
        res = '0;
        cross_q(na, nb, c);
        if (mag_sq(c) == 0) return res;
        m = unit_vec(c, dir);
        cross_q(na, dir, e0);
        void'(unit_vec(e0, e));
        for (int i = 0; i < 3; i++) pa[i] = rnd_sat(prod(na[i], w.plane_a_offset), 0);
        pdist = dist_to(nb, w.plane_b_offset, pa);
        r = div_sat(t_wide'(pdist) <<< 16, m);
        for (int i = 0; i < 3; i++) begin
            step = prod(e[i], r);
            pos[i] = rnd_sat(step, pa[i]);
            neg[i] = rnd_sat(-step, pa[i]);
        end
        if (err_sum(na, w.plane_a_offset, nb, w.plane_b_offset, pos) <
            err_sum(na, w.plane_a_offset, nb, w.plane_b_offset, neg)) pt = pos;
        else pt = neg;
        res.valid_res = 1'b1;
        res.line_point_x = pt[0];
        res.line_point_y = pt[1];
        res.line_point_z = pt[2];
        res.line_dir_x = dir[0];
        res.line_dir_y = dir[1];
        res.line_dir_z = dir[2];
        return res;
    endfunction

    // mostly modest q16.16 values, sometimes full range or extremes
    function automatic t_q rand_q();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            3: return 32'sd0;
            default: return $signed(32'($urandom_range(20 << 16))) - (10 << 16);
        endcase
    endfunction

    function automatic t_in_word rand_pair();
        t_in_word w;
        w.plane_a_normal_x = rand_q();
        w.plane_a_normal_y = rand_q();
        w.plane_a_normal_z = rand_q();
        w.plane_a_offset   = rand_q();
        w.plane_b_normal_x = rand_q();
        w.plane_b_normal_y = rand_q();
        w.plane_b_normal_z = rand_q();
        w.plane_b_offset   = rand_q();
        // parallel pair now and then
        if ($urandom_range(9) == 0) begin
            w.plane_b_normal_x = w.plane_a_normal_x;
            w.plane_b_normal_y = w.plane_a_normal_y;
            w.plane_b_normal_z = w.plane_a_normal_z;
        end
        return w;
    endfunction

    function automatic t_in_word mk(input t_q ax, input t_q ay, input t_q az, input t_q ao,
                                    input t_q bx, input t_q by, input t_q bz, input t_q bo);
        return '{ax, ay, az, ao, bx, by, bz, bo};
    endfunction

    // input handshake seen at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (in_taken) void'(pending_pairs.pop_front());
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_pairs[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (in_ch.valid && in_ch.ready) expected_lines.push_back(intersect_line(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_lines.size() == 0) begin
                    $error("unexpected output word");
                    n_fail++;
                end else begin
                    t_out_word e;
                    t_out_word a;
                    e = expected_lines.pop_front();
                    a = out_ch.data;
                    if (a.valid_res !== e.valid_res) begin
                        $error("valid_res exp %0d got %0d", e.valid_res, a.valid_res); n_fail++;
                    end
                    if (a.line_point_x !== e.line_point_x) begin
                        $error("line_point_x exp %0d got %0d", e.line_point_x, a.line_point_x);
                        n_fail++;
                    end
                    if (a.line_point_y !== e.line_point_y) begin
                        $error("line_point_y exp %0d got %0d", e.line_point_y, a.line_point_y);
                        n_fail++;
                    end
                    if (a.line_point_z !== e.line_point_z) begin
                        $error("line_point_z exp %0d got %0d", e.line_point_z, a.line_point_z);
                        n_fail++;
                    end
                    if (a.line_dir_x !== e.line_dir_x) begin
                        $error("line_dir_x exp %0d got %0d", e.line_dir_x, a.line_dir_x);
                        n_fail++;
                    end
                    if (a.line_dir_y !== e.line_dir_y) begin
                        $error("line_dir_y exp %0d got %0d", e.line_dir_y, a.line_dir_y);
                        n_fail++;
                    end
                    if (a.line_dir_z !== e.line_dir_z) begin
                        $error("line_dir_z exp %0d got %0d", e.line_dir_z, a.line_dir_z);
                        n_fail++;
                    end
                end
            end
            if (cycle_count > MAX_CYCLE) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    localparam t_q ONE = 32'sh00010000;

    initial begin
        n_fail = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 78;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: axis planes, parallel, equal, extremes, zero step
        pending_pairs.push_back(mk(ONE, 0, 0, ONE, 0, ONE, 0, 2 * ONE));
        pending_pairs.push_back(mk(0, 0, ONE, -ONE, ONE, 0, 0, 3 * ONE));
        pending_pairs.push_back(mk(ONE, 0, 0, ONE, ONE, 0, 0, 5 * ONE));
        pending_pairs.push_back(mk(ONE, ONE, 0, ONE, ONE, ONE, 0, ONE));
        pending_pairs.push_back(mk(0, 0, 0, 0, ONE, 0, 0, 0));
        pending_pairs.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                   32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
        pending_pairs.push_back(mk(32'sh80000000, 0, 32'sh7fffffff, 32'sh80000000,
                                   0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
        pending_pairs.push_back(mk(1, 0, 0, 1, 0, 1, 0, 1));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, 1, -1, -1));
        pending_pairs.push_back(mk(ONE, 0, 0, 0, 0, ONE, 0, 0));
        pending_pairs.push_back(mk(32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 32'sh7fffffff, 0,
                                   32'sh80000000));
        pending_pairs.push_back(mk(-ONE, 2 * ONE, 3 * ONE, 7 * ONE, 4 * ONE, -ONE, ONE, -2 * ONE));
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 167; k++) pending_pairs.push_back(rand_pair());
            while (pending_pairs.size() != 0) @(posedge i_clk);
            if (p == 0) begin
                send_idle_pct = 78;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
